@@ rtl/rectangle_rasterizer_macros.svh @@
// ----------------------------------------------------------------------------
// Rectangle rasterizer assertion macros
// Shared assertion forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef RECTANGLE_RASTERIZER_MACROS_SVH
`define RECTANGLE_RASTERIZER_MACROS_SVH

// The consequence must hold in the same cycle as the condition.
`define RR_ASSERT_SAME(label, cond, consq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (consq)) \
    else $error(msg);

// The consequence must hold in the cycle after the condition.
`define RR_ASSERT_NEXT(label, cond, consq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (consq)) \
    else $error(msg);

`endif

@@ rtl/rr_pkg.sv @@
// ----------------------------------------------------------------------------
// Rectangle rasterizer package
// Types, codes and defaults shared by the rasterizer files.
// ----------------------------------------------------------------------------
package rr_pkg;

  localparam int DEF_MAX_DIM   = 256;
  localparam int DEF_FRAC_BITS = 8;
  localparam int FIELD_BITS    = 20;
  localparam int CHAR_W        = 8;
  localparam int CFG_DIM_W     = 9;
  localparam int APB_ADDR_W    = 4;
  localparam int APB_DATA_W    = 32;

  localparam logic [CFG_DIM_W-1:0] RST_CANVAS_WIDTH  = 9'd256;
  localparam logic [CFG_DIM_W-1:0] RST_CANVAS_HEIGHT = 9'd256;
  localparam logic [CHAR_W-1:0]    RST_BACKGROUND    = 8'd32;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_DRAW  = 2'd1,
    CMD_READ  = 2'd2
  } rr_cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_REJECT  = 2'd1,
    STATUS_OUTSIDE = 2'd2
  } rr_status_t;

  typedef enum logic [1:0] {
    REG_CANVAS_WIDTH  = 2'd0,
    REG_CANVAS_HEIGHT = 2'd1,
    REG_BACKGROUND    = 2'd2
  } rr_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RDWAIT,
    ST_RESP
  } rr_state_t;

  typedef struct packed {
    logic                         start;
    logic                         draw;
    logic                         outline;
    logic [CHAR_W-1:0]            ch;
    logic signed [FIELD_BITS-1:0] left;
    logic signed [FIELD_BITS-1:0] top;
    logic signed [FIELD_BITS-1:0] width;
    logic signed [FIELD_BITS-1:0] height;
  } rr_scan_ctl_t;

endpackage

@@ rtl/rr_if.sv @@
// ----------------------------------------------------------------------------
// Rectangle rasterizer channels
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface rr_req_if import rr_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [1:0]                   cmd;
  logic                         outline_only;
  logic signed [FIELD_BITS-1:0] rect_left;
  logic signed [FIELD_BITS-1:0] rect_top;
  logic signed [FIELD_BITS-1:0] rect_width;
  logic signed [FIELD_BITS-1:0] rect_height;
  logic [CHAR_W-1:0]            paint_char;
  logic [7:0]                   pixel_col;
  logic [7:0]                   pixel_row;

  modport source (
    output valid, cmd, outline_only, rect_left, rect_top, rect_width, rect_height,
    output paint_char, pixel_col, pixel_row,
    input  ready
  );
  modport sink (
    input  valid, cmd, outline_only, rect_left, rect_top, rect_width, rect_height,
    input  paint_char, pixel_col, pixel_row,
    output ready
  );
endinterface

interface rr_rsp_if import rr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [CHAR_W-1:0] pixel_value;

  modport source (output valid, status, pixel_value, input ready);
  modport sink (input valid, status, pixel_value, output ready);
endinterface

@@ rtl/rr_ram.sv @@
// ----------------------------------------------------------------------------
// Rectangle rasterizer RAM
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module rr_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 65536,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/rr_scan.sv @@
// ----------------------------------------------------------------------------
// Rectangle rasterizer scanner
// Walks the canvas one pixel per cycle; writes every pixel on a clear, covered pixels on a draw.
// ----------------------------------------------------------------------------
module rr_scan import rr_pkg::*; #(
  parameter int  MAX_DIM   = DEF_MAX_DIM,
  parameter int  FRAC_BITS = DEF_FRAC_BITS,
  localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  localparam int ADDR_W    = 2 * IDX_W
) (
  input  logic              clk,
  input  logic              rst,
  input  rr_scan_ctl_t      ctl,
  input  logic [IDX_W-1:0]  col_last,
  input  logic [IDX_W-1:0]  row_last,
  output logic              busy,
  output logic              we,
  output logic [ADDR_W-1:0] waddr,
  output logic [CHAR_W-1:0] wdata
);

  localparam int CW = (((IDX_W + FRAC_BITS + 1) > (FIELD_BITS + 2)) ?
                       (IDX_W + FRAC_BITS + 1) : (FIELD_BITS + 2)) + 1;
  localparam logic signed [CW-1:0] UNIT = CW'(1) << FRAC_BITS;

  logic                 draw;
  logic                 outline;
  logic [CHAR_W-1:0]    ch;
  logic signed [CW-1:0] x1, x2, x1u, x2m;
  logic signed [CW-1:0] y1, y2, y1u, y2m;
  logic [IDX_W-1:0]     col;
  logic [IDX_W-1:0]     row;
  logic signed [CW-1:0] px, py;
  logic                 in_x, in_y, near_edge;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (ctl.start) begin
      busy <= 1'b1;
    end else if (busy && col == col_last && row == row_last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      draw    <= ctl.draw;
      outline <= ctl.outline;
      ch      <= ctl.ch;
      x1      <= CW'(ctl.left);
      x2      <= CW'(ctl.left) + CW'(ctl.width);
      x1u     <= CW'(ctl.left) + UNIT;
      x2m     <= CW'(ctl.left) + CW'(ctl.width) - UNIT;
      y1      <= CW'(ctl.top);
      y2      <= CW'(ctl.top) + CW'(ctl.height);
      y1u     <= CW'(ctl.top) + UNIT;
      y2m     <= CW'(ctl.top) + CW'(ctl.height) - UNIT;
      col     <= '0;
      row     <= '0;
    end else if (busy) begin
      if (col == col_last) begin
        col <= '0;
        row <= row + IDX_W'(1);
      end else begin
        col <= col + IDX_W'(1);
      end
    end
  end

  always_comb begin
    px        = $signed(CW'(col) << FRAC_BITS);
    py        = $signed(CW'(row) << FRAC_BITS);
    in_x      = (px >= x1) && (px <= x2);
    in_y      = (py >= y1) && (py <= y2);
    near_edge = (px < x1u) || (px > x2m) || (py < y1u) || (py > y2m);
    we        = busy && (!draw || (in_x && in_y && (!outline || near_edge)));
    waddr     = {row, col};
    wdata     = ch;
  end

endmodule

@@ rtl/rectangle_rasterizer.sv @@
// Flow: a clear or draw is accepted in ST_IDLE, runs ST_SCAN over the canvas, then ST_RESP;
// a read passes ST_RDWAIT then ST_RESP, and a rejected, out-of-canvas or unused item goes to ST_RESP.
// Items are accepted only in ST_IDLE, one at a time; the canvas RAM paints one pixel a cycle.
// Every clear or draw scans the whole canvas, all 65536 pixels at the full 256 by 256 size.
// Reset sets the registers to 256, 256 and 32; canvas contents stay undefined until a clear.
// ----------------------------------------------------------------------------
// Rectangle rasterizer
// Character canvas with clear, filled or outline rectangle draw, and pixel read.
// ----------------------------------------------------------------------------
`include "rectangle_rasterizer_macros.svh"

module rectangle_rasterizer import rr_pkg::*; #(
  parameter int MAX_DIM   = DEF_MAX_DIM,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  rr_req_if.sink                req,
  rr_rsp_if.source              rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int RAM_DEPTH = 1 << ADDR_W;
  localparam int DIM_W     = $clog2(MAX_DIM + 1);
  localparam int EW        = (DIM_W > CFG_DIM_W) ? DIM_W : CFG_DIM_W;
  localparam int CMPW      = (DIM_W > 8) ? DIM_W : 8;

  logic [CFG_DIM_W-1:0] canvas_width;
  logic [CFG_DIM_W-1:0] canvas_height;
  logic [CHAR_W-1:0]    background_char;
  logic [DIM_W-1:0]     w_eff, h_eff;
  logic [IDX_W-1:0]     col_last, row_last;

  rr_state_t         state, state_next;
  rr_status_t        status_q, status_next;
  logic              rd_ok, rd_ok_next;
  logic              out_load;
  logic              out_valid;
  logic [1:0]        out_status;
  logic [CHAR_W-1:0] out_value;

  logic              reject, outside;
  logic              scan_start;
  rr_scan_ctl_t      scan_ctl;
  logic              scan_busy;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CHAR_W-1:0] ram_wdata, ram_rdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width    <= RST_CANVAS_WIDTH;
      canvas_height   <= RST_CANVAS_HEIGHT;
      background_char <= RST_BACKGROUND;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_CANVAS_WIDTH:  canvas_width    <= pwdata[CFG_DIM_W-1:0];
        REG_CANVAS_HEIGHT: canvas_height   <= pwdata[CFG_DIM_W-1:0];
        REG_BACKGROUND:    background_char <= pwdata[CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pready = 1'b1;
    case (paddr[3:2])
      REG_CANVAS_WIDTH:  prdata = APB_DATA_W'(canvas_width);
      REG_CANVAS_HEIGHT: prdata = APB_DATA_W'(canvas_height);
      REG_BACKGROUND:    prdata = APB_DATA_W'(background_char);
      default:           prdata = '0;
    endcase
  end

  // Out-of-range canvas sizes are clamped to 1..MAX_DIM.
  always_comb begin
    if (canvas_width == '0) begin
      w_eff = DIM_W'(1);
    end else if (EW'(canvas_width) > EW'(MAX_DIM)) begin
      w_eff = DIM_W'(MAX_DIM);
    end else begin
      w_eff = DIM_W'(canvas_width);
    end
    if (canvas_height == '0) begin
      h_eff = DIM_W'(1);
    end else if (EW'(canvas_height) > EW'(MAX_DIM)) begin
      h_eff = DIM_W'(MAX_DIM);
    end else begin
      h_eff = DIM_W'(canvas_height);
    end
    col_last = IDX_W'(w_eff - DIM_W'(1));
    row_last = IDX_W'(h_eff - DIM_W'(1));
  end

  assign reject  = req.rect_width[FIELD_BITS-1] || (req.rect_width == '0) ||
                   req.rect_height[FIELD_BITS-1] || (req.rect_height == '0);
  assign outside = (CMPW'(req.pixel_col) >= CMPW'(w_eff)) ||
                   (CMPW'(req.pixel_row) >= CMPW'(h_eff));

  assign req.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    status_q <= status_next;
    rd_ok    <= rd_ok_next;
  end

  always_comb begin
    state_next  = state;
    status_next = status_q;
    rd_ok_next  = rd_ok;
    out_load    = 1'b0;
    ram_re      = 1'b0;
    scan_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          status_next = STATUS_OK;
          rd_ok_next  = 1'b0;
          case (req.cmd)
            CMD_CLEAR: begin
              scan_start = 1'b1;
              state_next = ST_SCAN;
            end
            CMD_DRAW: begin
              if (reject) begin
                status_next = STATUS_REJECT;
                state_next  = ST_RESP;
              end else begin
                scan_start = 1'b1;
                state_next = ST_SCAN;
              end
            end
            CMD_READ: begin
              if (outside) begin
                status_next = STATUS_OUTSIDE;
                state_next  = ST_RESP;
              end else begin
                ram_re     = 1'b1;
                rd_ok_next = 1'b1;
                state_next = ST_RDWAIT;
              end
            end
            default: state_next = ST_RESP;
          endcase
        end
      end
      ST_SCAN: begin
        if (!scan_busy) begin
          state_next = ST_RESP;
        end
      end
      ST_RDWAIT: state_next = ST_RESP;
      ST_RESP: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    scan_ctl.start   = scan_start;
    scan_ctl.draw    = (req.cmd == CMD_DRAW);
    scan_ctl.outline = req.outline_only;
    scan_ctl.ch      = (req.cmd == CMD_DRAW) ? req.paint_char : background_char;
    scan_ctl.left    = req.rect_left;
    scan_ctl.top     = req.rect_top;
    scan_ctl.width   = req.rect_width;
    scan_ctl.height  = req.rect_height;
    ram_raddr        = {IDX_W'(req.pixel_row), IDX_W'(req.pixel_col)};
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= status_q;
      out_value  <= rd_ok ? ram_rdata : '0;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.pixel_value = out_value;

  rr_scan #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .ctl      (scan_ctl),
    .col_last (col_last),
    .row_last (row_last),
    .busy     (scan_busy),
    .we       (ram_we),
    .waddr    (ram_waddr),
    .wdata    (ram_wdata)
  );

  rr_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (RAM_DEPTH)
  ) u_canvas (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  `RR_ASSERT_SAME(a_busy_blocks_input, scan_busy, !req.ready, "item accepted during scan")
  `RR_ASSERT_SAME(a_write_only_in_scan, ram_we, state == ST_SCAN, "canvas write outside scan")
  `RR_ASSERT_NEXT(a_reject_draw, req.valid && req.ready && req.cmd == CMD_DRAW && reject, state == ST_RESP && status_q == STATUS_REJECT, "bad rectangle not rejected")
  `RR_ASSERT_NEXT(a_result_loaded, state == ST_RESP && (!out_valid || rsp.ready), rsp.valid && state == ST_IDLE, "result not delivered")

endmodule
